@@ rtl/core/sab_pkg.sv @@
// Shared types and constants for the suffix automaton builder.
// No dependencies; every other file but sab_ram imports this package.
package sab_pkg;

    localparam int MAX_TEXT   = 1024;
    localparam int NUM_STATES = 2 * MAX_TEXT;
    localparam int ALPHA      = 26;
    localparam int SYM_W      = 5;
    localparam int ST_W       = $clog2(NUM_STATES);
    localparam int CNT_W      = ST_W + 1;
    localparam int TXT_W      = $clog2(MAX_TEXT) + 1;
    localparam int ROW_W      = ALPHA * ST_W;

    typedef logic [ALPHA-1:0][ST_W-1:0] t_row;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             restart;
    } t_in;

    typedef struct packed {
        logic [ST_W-1:0]  new_state;
        logic [ST_W-1:0]  link_state;
        logic             cloned;
        logic [CNT_W-1:0] states_used;
        logic             overflow;
    } t_out;

    // Controller to datapath: command strobes decoded from the controller state
    typedef struct packed {
        logic load;
        logic clr;
        logic chk;
        logic newst;
        logic wchk;
        logic qread;
        logic qchk;
        logic rchk;
        logic setq;
        logic fin;
        logic out;
        logic rd_last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic reject;
        logic has_tr;
        logic p_root;
        logic len_match;
        logic redir;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/core/sab_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/sab_ctrl.sv @@
// Sequencing state machine for the suffix automaton builder.
// Depends on sab_pkg for the command and status structs.
module sab_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_restart,
    input  sab_pkg::t_sts i_sts,
    output sab_pkg::t_cmd o_cmd
);
    import sab_pkg::*;

    typedef enum logic [14:0] {
        S_RST   = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_CLR   = 15'b000000000000100,
        S_CHK   = 15'b000000000001000,
        S_NEW   = 15'b000000000010000,
        S_WREAD = 15'b000000000100000,
        S_WCHK  = 15'b000000001000000,
        S_QREAD = 15'b000000010000000,
        S_QCHK  = 15'b000000100000000,
        S_RREAD = 15'b000001000000000,
        S_RCHK  = 15'b000010000000000,
        S_SETQ  = 15'b000100000000000,
        S_FIN   = 15'b001000000000000,
        S_OUT   = 15'b010000000000000,
        S_SPARE = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RST:   n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = i_restart ? S_CLR : S_CHK;
            S_CLR:   n_state = S_CHK;
            S_CHK:   n_state = i_sts.reject ? S_OUT : S_NEW;
            S_NEW:   n_state = S_WREAD;
            S_WREAD: n_state = S_WCHK;
            S_WCHK: begin
                if (i_sts.has_tr)      n_state = S_QREAD;
                else if (i_sts.p_root) n_state = S_FIN;
                else                   n_state = S_WREAD;
            end
            S_QREAD: n_state = S_QCHK;
            S_QCHK:  n_state = i_sts.len_match ? S_FIN : S_RREAD;
            S_RREAD: n_state = S_RCHK;
            S_RCHK: begin
                if (!i_sts.redir || i_sts.p_root) n_state = S_SETQ;
                else                              n_state = S_RREAD;
            end
            S_SETQ:  n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_RST;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    // Drive commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = (r_state == S_IDLE) && i_valid;
        o_cmd.clr     = (r_state == S_RST) || (r_state == S_CLR);
        o_cmd.chk     = (r_state == S_CHK);
        o_cmd.rd_last = (r_state == S_CHK);
        o_cmd.newst   = (r_state == S_NEW);
        o_cmd.wchk    = (r_state == S_WCHK);
        o_cmd.qread   = (r_state == S_QREAD);
        o_cmd.qchk    = (r_state == S_QCHK);
        o_cmd.rchk    = (r_state == S_RCHK);
        o_cmd.setq    = (r_state == S_SETQ);
        o_cmd.fin     = (r_state == S_FIN);
        o_cmd.out     = (r_state == S_OUT);
    end
endmodule

@@ rtl/core/sab_dp.sv @@
// Datapath: transition, length and link memories, walk registers, result word.
// Depends on sab_pkg and sab_ram.
module sab_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sab_pkg::t_in  i_data,
    input  sab_pkg::t_cmd i_cmd,
    output sab_pkg::t_sts o_sts,
    output logic          o_valid,
    input  logic          i_ready,
    output sab_pkg::t_out o_data
);
    import sab_pkg::*;

    logic [SYM_W-1:0] r_sym;
    logic [ST_W-1:0]  r_last, r_p, r_q, r_np, r_cl, r_lnk;
    logic [ST_W-1:0]  r_lenp;
    logic [CNT_W-1:0] r_total;
    logic [TXT_W-1:0] r_text;
    logic             r_cloned, r_ovf;
    logic             r_out_valid;
    t_out             r_out;

    logic [ST_W-1:0]  raddr;
    t_row             rd_row, wr_row_mod;
    logic [ROW_W-1:0] rd_row_bits;
    logic [ST_W-1:0]  rd_len, rd_link;
    logic [ST_W-1:0]  tr_val;

    logic             tr_we, len_we, link_we;
    logic [ST_W-1:0]  tr_waddr, len_waddr, link_waddr;
    t_row             tr_wdata;
    logic [ST_W-1:0]  len_wdata, link_wdata;
    logic             ovf, bad;

    assign rd_row = t_row'(rd_row_bits);
    assign tr_val = rd_row[r_sym];

    // Select the read address shared by all three memories
    always_comb begin
        raddr = r_p;
        if (i_cmd.rd_last)    raddr = r_last;
        else if (i_cmd.qread) raddr = r_q;
    end

    // Capacity and symbol checks
    assign ovf = (r_text >= TXT_W'(MAX_TEXT)) ||
                 (({1'b0, r_total} + (CNT_W+1)'(2)) > (CNT_W+1)'(NUM_STATES));
    assign bad = (r_sym >= SYM_W'(ALPHA));

    // Row with the current symbol's entry replaced
    always_comb begin
        wr_row_mod = rd_row;
        wr_row_mod[r_sym] = i_cmd.rchk ? r_cl : r_np;
    end

    // Memory write selection; the clone takes the next free index
    always_comb begin
        tr_we = 1'b0;   tr_waddr = r_p;      tr_wdata = wr_row_mod;
        len_we = 1'b0;  len_waddr = r_np;    len_wdata = rd_len + ST_W'(1);
        link_we = 1'b0; link_waddr = r_np;   link_wdata = r_lnk;
        if (i_cmd.clr) begin
            tr_we = 1'b1;   tr_waddr = '0;   tr_wdata = '0;
            len_we = 1'b1;  len_waddr = '0;  len_wdata = '0;
            link_we = 1'b1; link_waddr = '0; link_wdata = '0;
        end else if (i_cmd.newst) begin
            tr_we = 1'b1;   tr_waddr = r_np; tr_wdata = '0;
            len_we = 1'b1;
        end else if (i_cmd.wchk) begin
            tr_we = (tr_val == '0);
        end else if (i_cmd.qchk) begin
            tr_we   = (rd_len != r_lenp + ST_W'(1));
            tr_waddr = r_total[ST_W-1:0]; tr_wdata = rd_row;
            len_we  = tr_we; len_waddr = r_total[ST_W-1:0];
            len_wdata = r_lenp + ST_W'(1);
            link_we = tr_we; link_waddr = r_total[ST_W-1:0]; link_wdata = rd_link;
        end else if (i_cmd.rchk) begin
            tr_we = (tr_val == r_q);
        end else if (i_cmd.setq) begin
            link_we = 1'b1; link_waddr = r_q; link_wdata = r_cl;
        end else if (i_cmd.fin) begin
            link_we = 1'b1;
        end
    end

    sab_ram #(.WIDTH(ROW_W), .DEPTH(NUM_STATES)) u_tr (
        .i_clk(i_clk), .i_we(tr_we), .i_waddr(tr_waddr),
        .i_wdata(ROW_W'(tr_wdata)), .i_raddr(raddr), .o_rdata(rd_row_bits)
    );

    sab_ram #(.WIDTH(ST_W), .DEPTH(NUM_STATES)) u_len (
        .i_clk(i_clk), .i_we(len_we), .i_waddr(len_waddr),
        .i_wdata(len_wdata), .i_raddr(raddr), .o_rdata(rd_len)
    );

    sab_ram #(.WIDTH(ST_W), .DEPTH(NUM_STATES)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr),
        .i_wdata(link_wdata), .i_raddr(raddr), .o_rdata(rd_link)
    );

    // Counters and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_total     <= CNT_W'(1);
            r_text      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_last  <= '0;
                r_total <= CNT_W'(1);
                r_text  <= '0;
            end else if (i_cmd.chk && !ovf && !bad) begin
                r_total <= r_total + CNT_W'(1);
            end else if (i_cmd.qchk && tr_we) begin
                r_total <= r_total + CNT_W'(1);
            end else if (i_cmd.fin) begin
                r_last <= r_np;
                r_text <= r_text + TXT_W'(1);
            end
            if (i_cmd.out && o_sts.out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk and result payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym <= i_data.symbol;
        end
        if (i_cmd.chk) begin
            r_np     <= (ovf || bad) ? '0 : r_total[ST_W-1:0];
            r_lnk    <= '0;
            r_cloned <= 1'b0;
            r_ovf    <= ovf;
            r_p      <= r_last;
        end
        if (i_cmd.wchk) begin
            if (tr_val != '0) begin
                r_q    <= tr_val;
                r_lenp <= rd_len;
            end else begin
                r_p <= rd_link;
            end
        end
        if (i_cmd.qchk) begin
            if (tr_we) begin
                r_cl     <= r_total[ST_W-1:0];
                r_cloned <= 1'b1;
            end else begin
                r_lnk <= r_q;
            end
        end
        if (i_cmd.rchk) begin
            r_p <= rd_link;
        end
        if (i_cmd.setq) begin
            r_lnk <= r_cl;
        end
        if (i_cmd.out && o_sts.out_free) begin
            r_out.new_state   <= r_np;
            r_out.link_state  <= r_lnk;
            r_out.cloned      <= r_cloned;
            r_out.states_used <= r_total;
            r_out.overflow    <= r_ovf;
        end
    end

    // Status back to the controller
    always_comb begin
        o_sts.reject    = ovf || bad;
        o_sts.has_tr    = (tr_val != '0);
        o_sts.p_root    = (r_p == '0);
        o_sts.len_match = (rd_len == r_lenp + ST_W'(1));
        o_sts.redir     = (tr_val == r_q);
        o_sts.out_free  = !r_out_valid || i_ready;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
endmodule

@@ rtl/core/suffix_automaton_builder.sv @@
// Suffix automaton builder: top level joining controller and datapath.
// Depends on sab_pkg, sab_ctrl, sab_dp (and sab_ram through sab_dp).
//
// Usage:
//   Input channel (i_valid/o_ready, i_data): one word per symbol, with a
//   restart bit that clears the automaton to the root before the symbol.
//   Output channel (o_valid/i_ready, o_data): exactly one result word per
//   input word, in order.
//   One word is worked on at a time. A rejected symbol goes from the check
//   straight to the output state; otherwise a new state is made and the
//   suffix links are walked. Finding an existing transition adds a read and
//   check of its target, and a clone adds a walk that redirects transitions
//   and a link update. Restart adds a clear state. The next word is accepted
//   once the result is loaded and the block is idle again. Every walk step is
//   one read of the row-wide transition memory (one state's 26 entries per
//   word) followed by a check of the row read.
//   After reset the block clears the root row in its reset state, then
//   accepts words. A stalled receiver holds the result in the output
//   register; the block accepts and works the next word meanwhile and
//   waits to deliver it until the register is free.
module suffix_automaton_builder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sab_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output sab_pkg::t_out o_data
);
    import sab_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sab_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_restart(i_data.restart), .i_sts(sts), .o_cmd(cmd)
    );

    sab_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_data(i_data), .i_cmd(cmd),
        .o_sts(sts), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );
endmodule

@@ rtl/core/sab_checker.sv @@
// Port-level checks for the suffix automaton builder, bound to the top level.
// Depends on sab_pkg and suffix_automaton_builder.
module sab_port_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input sab_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input sab_pkg::t_out o_data
);
    import sab_pkg::*;

    // Hold a stalled result word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    // Overflow result words carry no state
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.overflow |->
            o_data.new_state == '0 && o_data.link_state == '0 && !o_data.cloned)
        else $error("overflow result carries state");

    // A clone is allocated right after the new state
    a_clone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.cloned |->
            o_data.link_state == o_data.new_state + ST_W'(1))
        else $error("clone index mismatch");

    // No result right after reset
    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid after reset");
endmodule

bind suffix_automaton_builder sab_port_checker u_sab_checker (.*);
